### hw/rtl/dmbrc_pkg.sv
package dmbrc_pkg;

  localparam int CACHE_LINES     = 8;
  localparam int BLOCK_MAX_BYTES = 4096;
  localparam int DISKS           = 32;
  localparam int CMD_FIFO_DEPTH  = 4;

  localparam logic [3:0]  SHIFT_RESET = 4'd9;
  localparam logic [3:0]  SHIFT_MIN   = 4'd9;
  localparam logic [3:0]  SHIFT_MAX   = 4'd12;
  localparam logic [15:0] GEN_MAX     = 16'hFFFF;

  // register index (paddr[2])
  localparam logic REG_BLOCK_SHIFT = 1'b0;

  localparam logic [1:0] OP_READ       = 2'd0;
  localparam logic [1:0] OP_FILL       = 2'd1;
  localparam logic [1:0] OP_FILL_ERROR = 2'd2;
  localparam logic [1:0] OP_RESCAN     = 2'd3;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FETCH  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_RD_ERR  = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [30:0] fetch_lba;
    logic [4:0]  fetch_slot;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        has_result;
    logic        rd_en;
    logic [2:0]  byte_sel;
    logic        wr_en;
    logic [63:0] wr_data;
    result_t     res;
  } cmd_t;

  // clamp to 512..4096 bytes, then shrink to fit the largest block
  function automatic logic [3:0] eff_shift(input logic [3:0] bs, input int max_bytes);
    logic [3:0] s;
    s = bs;
    if (s < SHIFT_MIN) s = SHIFT_MIN;
    if (s > SHIFT_MAX) s = SHIFT_MAX;
    for (int i = 0; i < 3; i++) begin
      if (s > SHIFT_MIN && (32'd1 << s) > 32'(max_bytes)) s = s - 4'd1;
    end
    return s;
  endfunction

endpackage

### hw/rtl/dmbrc_ram.sv
module dmbrc_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/dmbrc_cmd_fifo.sv
module dmbrc_cmd_fifo #(
  parameter int Width = 64,
  parameter int Depth = dmbrc_pkg::CMD_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wr_data,
  input  logic             pop,
  output logic [Width-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;

  assign empty   = (count == '0);
  assign full    = (count == CntW'(Depth));
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

endmodule

### hw/rtl/dmbrc_front.sv
module dmbrc_front #(
  parameter int CacheLines    = dmbrc_pkg::CACHE_LINES,
  parameter int BlockMaxBytes = dmbrc_pkg::BLOCK_MAX_BYTES,
  parameter int Disks         = dmbrc_pkg::DISKS,
  localparam int WordsPerLine = BlockMaxBytes / 8,
  localparam int AddrW        = $clog2(CacheLines * WordsPerLine)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         shift,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [127:0]       s_tdata,
  input  logic [1:0]         s_tuser,
  input  logic               s_tlast,
  output logic               push,
  output dmbrc_pkg::cmd_t    cmd,
  output logic [AddrW-1:0]   rd_addr,
  output logic [AddrW-1:0]   wr_addr,
  input  logic               q_full
);

  localparam int LineW  = (CacheLines > 1) ? $clog2(CacheLines) : 1;
  localparam bit IsPow2 = (CacheLines & (CacheLines - 1)) == 0;

  // held request
  logic        hold_valid;
  logic [1:0]  hold_op;
  logic [4:0]  hold_slot;
  logic [15:0] hold_gen;
  logic [39:0] hold_addr;
  logic        hold_last;
  logic [63:0] hold_fill;

  // cache state
  logic [15:0]      cur_gen;
  logic [CacheLines-1:0] line_valid;
  logic [15:0]      gen_tag  [CacheLines];
  logic [4:0]       slot_tag [CacheLines];
  logic [30:0]      lba_tag  [CacheLines];
  logic             miss_pending;
  logic [30:0]      pend_lba;
  logic [4:0]       pend_slot;
  logic [11:0]      pend_intra;
  logic             pend_last;
  logic [LineW-1:0] pend_line;
  logic [8:0]       fill_cnt;

  logic             take;
  logic             retire;
  logic [12:0]      bsize;
  logic [11:0]      mask;
  logic [9:0]       words;
  logic [30:0]      lba;
  logic [11:0]      intra;
  logic [30:0]      key;
  logic [LineW-1:0] line;
  logic             line_ready;
  logic             hit;
  logic [11:0]      pintra;
  logic [8:0]       fill_inc;
  logic             fill_done;
  logic             do_clear;
  logic             do_miss;
  logic             do_fill;
  logic             do_abort;
  logic             do_gen_inc;

  function automatic logic [AddrW-1:0] ram_addr(input logic [LineW-1:0] ln,
                                                input logic [8:0] wd);
    return AddrW'(32'(ln) * WordsPerLine + 32'(wd));
  endfunction

  assign take     = s_tvalid && s_tready;
  assign retire   = hold_valid && line_ready && !q_full;
  assign s_tready = !hold_valid || retire;

  always_comb begin
    bsize = 13'd1 << shift;
    mask  = 12'(bsize - 13'd1);
    words = bsize[12:3];
    lba   = 31'(hold_addr >> shift);
    intra = hold_addr[11:0] & mask;
    key   = lba ^ {26'd0, hold_slot};
  end

  generate
    if (IsPow2) begin : g_mask
      assign line       = LineW'(key) & LineW'(CacheLines - 1);
      assign line_ready = 1'b1;
    end else begin : g_rem
      // remainder by restoring steps, eight key bits per cycle, msb first
      localparam int RemW = LineW + 1;
      logic [2:0]       mod_cnt;
      logic [LineW-1:0] mod_rem;
      logic [LineW-1:0] rem_next;
      logic [RemW-1:0]  r;
      logic [7:0]       chunk;

      always_comb begin
        chunk = 8'({1'b0, key} >> {~mod_cnt[1:0], 3'b000});
        r     = RemW'(mod_rem);
        for (int i = 0; i < 8; i++) begin
          r = {r[LineW-1:0], chunk[7-i]};
          if (r >= RemW'(CacheLines)) r = r - RemW'(CacheLines);
        end
        rem_next = r[LineW-1:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          mod_cnt <= '0;
          mod_rem <= '0;
        end else if (take) begin
          mod_cnt <= '0;
          mod_rem <= '0;
        end else if (hold_valid && mod_cnt != 3'd4) begin
          mod_cnt <= mod_cnt + 3'd1;
          mod_rem <= rem_next;
        end
      end

      assign line       = mod_rem;
      assign line_ready = (hold_op != dmbrc_pkg::OP_READ) || (mod_cnt == 3'd4);
    end
  endgenerate

  assign hit = line_valid[line] && gen_tag[line] == hold_gen &&
               slot_tag[line] == hold_slot && lba_tag[line] == lba;

  always_comb begin
    pintra    = pend_intra & mask;
    fill_inc  = fill_cnt + 9'd1;
    fill_done = (fill_inc == '0) || ({1'b0, fill_inc} >= words);
  end

  always_comb begin
    cmd        = '0;
    rd_addr    = '0;
    wr_addr    = '0;
    do_clear   = 1'b0;
    do_miss    = 1'b0;
    do_fill    = 1'b0;
    do_abort   = 1'b0;
    do_gen_inc = 1'b0;
    unique case (hold_op)
      dmbrc_pkg::OP_READ: begin
        cmd.has_result = 1'b1;
        cmd.res.kind   = dmbrc_pkg::KIND_STATUS;
        if (32'(hold_slot) >= Disks) begin
          cmd.res.status = dmbrc_pkg::ST_INVALID;
        end else if (hold_gen != cur_gen) begin
          cmd.res.status = dmbrc_pkg::ST_STALE;
        end else if (miss_pending) begin
          cmd.res.status = dmbrc_pkg::ST_BUSY;
        end else if (hit) begin
          cmd.rd_en       = 1'b1;
          cmd.byte_sel    = intra[2:0];
          cmd.res.kind    = dmbrc_pkg::KIND_DATA;
          cmd.res.status  = dmbrc_pkg::ST_OK;
          cmd.res.last    = hold_last;
          rd_addr         = ram_addr(line, intra[11:3]);
        end else begin
          do_miss            = 1'b1;
          cmd.res.kind       = dmbrc_pkg::KIND_FETCH;
          cmd.res.status     = dmbrc_pkg::ST_OK;
          cmd.res.fetch_lba  = lba;
          cmd.res.fetch_slot = hold_slot;
        end
      end
      dmbrc_pkg::OP_FILL: begin
        if (!miss_pending) begin
          cmd.has_result = 1'b1;
          cmd.res.kind   = dmbrc_pkg::KIND_STATUS;
          cmd.res.status = dmbrc_pkg::ST_INVALID;
        end else begin
          do_fill      = 1'b1;
          cmd.wr_en    = 32'(fill_cnt) < WordsPerLine;
          cmd.wr_data  = hold_fill;
          wr_addr      = ram_addr(pend_line, fill_cnt);
          if (fill_done) begin
            cmd.has_result = 1'b1;
            cmd.res.kind   = dmbrc_pkg::KIND_DATA;
            cmd.res.status = dmbrc_pkg::ST_OK;
            cmd.res.last   = pend_last;
            cmd.byte_sel   = pintra[2:0];
            // requested word is the one arriving now: take it straight
            if (pintra[11:3] == fill_cnt) begin
              cmd.res.data_byte = 8'(hold_fill >> {pintra[2:0], 3'b000});
            end else begin
              cmd.rd_en = 1'b1;
              rd_addr   = ram_addr(pend_line, pintra[11:3]);
            end
          end
        end
      end
      dmbrc_pkg::OP_FILL_ERROR: begin
        do_clear = 1'b1;
        if (miss_pending) begin
          do_abort       = 1'b1;
          cmd.has_result = 1'b1;
          cmd.res.kind   = dmbrc_pkg::KIND_STATUS;
          cmd.res.status = dmbrc_pkg::ST_RD_ERR;
        end
      end
      dmbrc_pkg::OP_RESCAN: begin
        cmd.has_result = 1'b1;
        cmd.res.kind   = dmbrc_pkg::KIND_STATUS;
        if (miss_pending || cur_gen == dmbrc_pkg::GEN_MAX) begin
          cmd.res.status = dmbrc_pkg::ST_INVALID;
        end else begin
          do_gen_inc     = 1'b1;
          do_clear       = 1'b1;
          cmd.res.status = dmbrc_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    push = retire && (cmd.has_result || cmd.wr_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (retire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_op   <= s_tuser;
      hold_slot <= s_tdata[4:0];
      hold_gen  <= s_tdata[20:5];
      hold_addr <= s_tdata[60:21];
      hold_fill <= s_tdata[124:61];
      hold_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gen      <= '0;
      line_valid   <= '0;
      miss_pending <= 1'b0;
      pend_lba     <= '0;
      pend_slot    <= '0;
      pend_intra   <= '0;
      pend_last    <= 1'b0;
      pend_line    <= '0;
      fill_cnt     <= '0;
    end else if (retire) begin
      if (do_clear) line_valid <= '0;
      if (do_gen_inc) cur_gen <= cur_gen + 16'd1;
      if (do_miss) begin
        line_valid[line] <= 1'b0;
        miss_pending     <= 1'b1;
        fill_cnt         <= '0;
        pend_lba         <= lba;
        pend_slot        <= hold_slot;
        pend_intra       <= intra;
        pend_last        <= hold_last;
        pend_line        <= line;
      end
      if (do_fill) begin
        fill_cnt <= fill_done ? '0 : fill_inc;
        if (fill_done) begin
          miss_pending          <= 1'b0;
          line_valid[pend_line] <= 1'b1;
        end
      end
      if (do_abort) begin
        miss_pending <= 1'b0;
        fill_cnt     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && do_fill && fill_done) begin
      gen_tag[pend_line]  <= cur_gen;
      slot_tag[pend_line] <= pend_slot;
      lba_tag[pend_line]  <= pend_lba;
    end
  end

endmodule

### hw/rtl/dmbrc_back.sv
module dmbrc_back #(
  parameter int CacheLines    = dmbrc_pkg::CACHE_LINES,
  parameter int BlockMaxBytes = dmbrc_pkg::BLOCK_MAX_BYTES,
  localparam int WordsPerLine = BlockMaxBytes / 8,
  localparam int RamDepth     = CacheLines * WordsPerLine,
  localparam int AddrW        = $clog2(RamDepth)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dmbrc_pkg::cmd_t  q_cmd,
  input  logic [AddrW-1:0] q_rd_addr,
  input  logic [AddrW-1:0] q_wr_addr,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic               s1_valid;
  dmbrc_pkg::result_t s1_res;
  logic               s1_use_ram;
  logic [2:0]         s1_sel;
  dmbrc_pkg::result_t s1_out;
  dmbrc_pkg::result_t out_res;
  logic [63:0]        rdata;
  logic [7:0]         ram_byte;
  logic               out_free;
  logic               advance;

  assign out_free = !m_tvalid || m_tready;
  // stage 1 only moves when it is empty or the output register can take it, so the
  // registered RAM data holds while stalled
  assign advance  = !s1_valid || out_free;
  assign q_pop    = q_valid && advance;
  assign ram_byte = 8'(rdata >> {s1_sel, 3'b000});

  dmbrc_ram #(
    .Width(64),
    .Depth(RamDepth)
  ) u_data (
    .clk  (clk),
    .we   (q_pop && q_cmd.wr_en),
    .waddr(q_wr_addr),
    .wdata(q_cmd.wr_data),
    .re   (q_pop && q_cmd.rd_en),
    .raddr(q_rd_addr),
    .rdata(rdata)
  );

  always_comb begin
    s1_out = s1_res;
    if (s1_use_ram) s1_out.data_byte = ram_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) s1_valid <= q_pop && q_cmd.has_result;
      if (out_free) m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_res     <= q_cmd.res;
      s1_use_ram <= q_cmd.rd_en;
      s1_sel     <= q_cmd.byte_sel;
    end
    if (out_free) out_res <= s1_out;
  end

  assign m_tdata = {1'b0, out_res.fetch_slot, out_res.fetch_lba, out_res.status,
                    out_res.data_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

### hw/rtl/direct_mapped_block_read_cache_unit.sv
// Byte-granular read cache over disk blocks, direct mapped.
// Request stream (s_*): s_tuser carries the op (read byte, fill word, fill
// error, rescan), s_tlast marks the last byte of a caller request, s_tdata
// the slot, generation, byte address and fill word.
// Result stream (m_*): m_tuser carries the kind (data byte, fetch request,
// status), m_tlast echoes the request's last flag with a data byte.
// A miss answers with a fetch request; the block then expects its words as
// fill requests and answers the wanted byte after the last one.
// With a power-of-two line count one request is taken per cycle (hits and
// fill words alike) while the command queue has room; otherwise a read
// first passes through the line-index remainder unit (8 bits a cycle)
// before it is classified.
// A front stage classifies against the tags, a 4-entry command queue feeds
// the back stage, which owns the line data RAM and the output register.
// A stalled m_tready fills the queue, then s_tready drops.
// Reset clears all lines, the generation, any pending miss; block_shift
// returns to 9. No clearing pass is needed, the line RAM is qualified by
// per-line valid bits. Write block_shift only while idle.
module direct_mapped_block_read_cache_unit #(
  parameter int CACHE_LINES     = dmbrc_pkg::CACHE_LINES,
  parameter int BLOCK_MAX_BYTES = dmbrc_pkg::BLOCK_MAX_BYTES,
  parameter int DISKS           = dmbrc_pkg::DISKS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [4:0] disk_slot, [20:5] request_generation, [60:21] byte_address,
  // [124:61] fill_word, [127:125] zero
  input  logic [127:0] s_tdata,
  input  logic [1:0]   s_tuser,   // [1:0] op
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] data_byte, [10:8] status, [41:11] fetch_lba, [46:42] fetch_slot,
  // [47] zero
  output logic [47:0]  m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] kind
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int WordsPerLine = BLOCK_MAX_BYTES / 8;
  localparam int AddrW        = $clog2(CACHE_LINES * WordsPerLine);
  localparam int QW           = 2 * AddrW + $bits(dmbrc_pkg::cmd_t);

  logic [3:0]       block_shift;
  logic [3:0]       shift;
  logic             push;
  dmbrc_pkg::cmd_t  f_cmd;
  logic [AddrW-1:0] f_rd_addr;
  logic [AddrW-1:0] f_wr_addr;
  logic [QW-1:0]    q_out;
  logic             q_empty;
  logic             q_full;
  logic             q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dmbrc_pkg::REG_BLOCK_SHIFT) ? {28'd0, block_shift} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= dmbrc_pkg::SHIFT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == dmbrc_pkg::REG_BLOCK_SHIFT) begin
      block_shift <= pwdata[3:0];
    end
  end

  assign shift = dmbrc_pkg::eff_shift(block_shift, BLOCK_MAX_BYTES);

  dmbrc_front #(
    .CacheLines   (CACHE_LINES),
    .BlockMaxBytes(BLOCK_MAX_BYTES),
    .Disks        (DISKS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .push    (push),
    .cmd     (f_cmd),
    .rd_addr (f_rd_addr),
    .wr_addr (f_wr_addr),
    .q_full  (q_full)
  );

  dmbrc_cmd_fifo #(
    .Width(QW),
    .Depth(dmbrc_pkg::CMD_FIFO_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data({f_rd_addr, f_wr_addr, f_cmd}),
    .pop    (q_pop),
    .rd_data(q_out),
    .empty  (q_empty),
    .full   (q_full)
  );

  dmbrc_back #(
    .CacheLines   (CACHE_LINES),
    .BlockMaxBytes(BLOCK_MAX_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_empty),
    .q_cmd    (q_out[$bits(dmbrc_pkg::cmd_t)-1:0]),
    .q_rd_addr(q_out[QW-1 -: AddrW]),
    .q_wr_addr(q_out[QW-AddrW-1 -: AddrW]),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/direct_mapped_block_read_cache_unit_tb.sv
module direct_mapped_block_read_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmbrc_pkg::*;

  localparam int WORDS_PER_LINE = BLOCK_MAX_BYTES / 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [4:0]  slot;
    logic [39:0] base;
  } block_ref_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  direct_mapped_block_read_cache_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // cache mirror
  logic [3:0]             shift_reg;
  logic [15:0]            cur_gen;
  logic [CACHE_LINES-1:0] line_ok;
  logic [15:0]            tag_gen  [CACHE_LINES];
  logic [4:0]             tag_slot [CACHE_LINES];
  logic [30:0]            tag_lba  [CACHE_LINES];
  logic [63:0]            line_mem [CACHE_LINES*WORDS_PER_LINE];
  bit                     miss_busy;
  logic [30:0]            pend_lba;
  logic [4:0]             pend_slot;
  logic [11:0]            pend_off;
  logic                   pend_last;
  logic [8:0]             fill_cnt;

  result_t    pending_replies[$];
  block_ref_t recent_blocks[$];
  int         fails = 0;
  int         items_sent = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_idle_pct);

  function automatic int block_log2();
    int s;
    s = int'(shift_reg);
    if (s < int'(SHIFT_MIN)) s = int'(SHIFT_MIN);
    if (s > int'(SHIFT_MAX)) s = int'(SHIFT_MAX);
    while (s > int'(SHIFT_MIN) && (1 << s) > BLOCK_MAX_BYTES) s--;
    return s;
  endfunction

  function automatic int block_words();
    return (1 << block_log2()) / 8;
  endfunction

  function automatic logic [7:0] line_byte(input int line, input int off);
    logic [63:0] w;
    w = line_mem[line*WORDS_PER_LINE + off/8];
    return w[(off%8)*8 +: 8];
  endfunction

  task automatic predict_reply(input logic [1:0] op, input logic [4:0] slot,
                               input logic [15:0] gen, input logic [39:0] addr,
                               input logic lst, input logic [63:0] word);
    int sh;
    int line;
    int off;
    logic [30:0] lba;
    result_t r;
    bit emit;
    sh = block_log2();
    r = '0;
    r.kind = KIND_STATUS;
    emit = 1'b1;
    case (op)
      OP_READ: begin
        lba = 31'(addr >> sh);
        off = int'(addr[11:0]) & ((1 << sh) - 1);
        line = int'((lba ^ 31'(slot)) % CACHE_LINES);
        if (int'(slot) >= DISKS) begin
          r.status = ST_INVALID;
        end else if (gen != cur_gen) begin
          r.status = ST_STALE;
        end else if (miss_busy) begin
          r.status = ST_BUSY;
        end else if (line_ok[line] && tag_gen[line] == gen && tag_slot[line] == slot &&
                     tag_lba[line] == lba) begin
          r.kind = KIND_DATA;
          r.data_byte = line_byte(line, off);
          r.last = lst;
        end else begin
          line_ok[line] = 1'b0;
          miss_busy = 1'b1;
          fill_cnt = '0;
          pend_lba = lba;
          pend_slot = slot;
          pend_off = 12'(off);
          pend_last = lst;
          r.kind = KIND_FETCH;
          r.fetch_lba = lba;
          r.fetch_slot = slot;
        end
      end
      OP_FILL: begin
        if (!miss_busy) begin
          r.status = ST_INVALID;
        end else begin
          line = int'((pend_lba ^ 31'(pend_slot)) % CACHE_LINES);
          off = int'(pend_off) & ((1 << sh) - 1);
          if (int'(fill_cnt) < WORDS_PER_LINE) begin
            line_mem[line*WORDS_PER_LINE + int'(fill_cnt)] = word;
          end
          fill_cnt = fill_cnt + 9'd1;
          // a 4096-byte block wraps the counter to zero on its last word
          if (fill_cnt == '0 || int'(fill_cnt) >= (1 << sh) / 8) begin
            fill_cnt = '0;
            miss_busy = 1'b0;
            tag_gen[line] = cur_gen;
            tag_slot[line] = pend_slot;
            tag_lba[line] = pend_lba;
            line_ok[line] = 1'b1;
            r.kind = KIND_DATA;
            r.data_byte = line_byte(line, off);
            r.last = pend_last;
          end else begin
            emit = 1'b0;
          end
        end
      end
      OP_FILL_ERROR: begin
        line_ok = '0;
        if (miss_busy) begin
          miss_busy = 1'b0;
          fill_cnt = '0;
          r.status = ST_RD_ERR;
        end else begin
          emit = 1'b0;
        end
      end
      default: begin
        if (miss_busy || cur_gen == GEN_MAX) begin
          r.status = ST_INVALID;
        end else begin
          cur_gen = cur_gen + 16'd1;
          line_ok = '0;
          r.status = ST_OK;
        end
      end
    endcase
    if (emit) pending_replies.push_back(r);
  endtask

  // called and returns at a rising edge; acceptance is seen at the falling edge before it
  task automatic send_request(input logic [1:0] op, input logic [4:0] slot,
                              input logic [15:0] gen, input logic [39:0] addr,
                              input logic lst, input logic [63:0] word);
    bit taken;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tlast <= lst;
    s_tdata <= {3'b000, word, addr, gen, slot};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    items_sent++;
    predict_reply(op, slot, gen, addr, lst, word);
  endtask

  task automatic send_read(input logic [4:0] slot, input logic [15:0] gen,
                           input logic [39:0] addr, input logic lst);
    send_request(OP_READ, slot, gen, addr, lst, {$urandom, $urandom});
  endtask

  task automatic send_fill(input logic [63:0] word);
    send_request(OP_FILL, 5'($urandom), 16'($urandom), {8'($urandom), $urandom},
                 1'($urandom), word);
  endtask

  task automatic send_op(input logic [1:0] op);
    send_request(op, 5'($urandom), 16'($urandom), {8'($urandom), $urandom},
                 1'($urandom), {$urandom, $urandom});
  endtask

  task automatic fill_line(input int n);
    repeat (n) send_fill({$urandom, $urandom});
  endtask

  task automatic wait_results_done(input int extra);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // lines are dropped first so no hit can land on words a shorter block left unfilled
  task automatic set_block_shift(input logic [3:0] v);
    logic [31:0] rd;
    send_op(OP_FILL_ERROR);
    wait_results_done(8);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_BLOCK_SHIFT, 2'b00};
    pwdata <= {28'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shift_reg = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {28'd0, v}) begin
      $error("block_shift: expected %0d, got %0d", v, rd);
      fails++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_reply();
    result_t want;
    if (pending_replies.size() == 0) begin
      $error("unexpected reply: kind 0x%0h data 0x%0h", m_tuser, m_tdata);
      fails++;
      return;
    end
    want = pending_replies.pop_front();
    check_field("kind", 32'(want.kind), 32'(m_tuser));
    check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
    check_field("status", 32'(want.status), 32'(m_tdata[10:8]));
    check_field("fetch_lba", 32'(want.fetch_lba), 32'(m_tdata[41:11]));
    check_field("fetch_slot", 32'(want.fetch_slot), 32'(m_tdata[46:42]));
    check_field("last", 32'(want.last), 32'(m_tlast));
  endtask

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) check_reply();
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("direct_mapped_block_read_cache_unit_tb NOT OK");
    $finish;
  end

  task automatic test_directed_requests();
    send_read(5'd0, 16'd0, 40'd0, 1'b0);          // miss on an empty cache
    send_read(5'd3, 16'd0, 40'h200, 1'b1);         // busy while the miss is open
    send_op(OP_RESCAN);                            // refused while busy
    fill_line(block_words());
    send_read(5'd0, 16'd0, 40'd511, 1'b1);         // hit on the top byte
    send_read(5'd0, 16'hFFFF, 40'd0, 1'b0);        // stale generation
    send_fill(64'hFFFF_FFFF_FFFF_FFFF);            // fill word with no miss
    send_op(OP_FILL_ERROR);                        // no miss: silent, lines dropped
    send_read(5'd0, 16'd0, 40'd7, 1'b0);           // misses again
    fill_line(10);
    send_op(OP_FILL_ERROR);                        // aborts the fill
    send_op(OP_RESCAN);
    send_read(5'd31, 16'd1, 40'hFF_FFFF_FFFF, 1'b1);
    fill_line(block_words());
    send_read(5'd31, 16'd1, 40'hFF_FFFF_FE00, 1'b0);
    send_read(5'd31, 16'd0, 40'hFF_FFFF_FE00, 1'b1);
  endtask

  task automatic test_block_sizes();
    set_block_shift(4'd15);                        // clamps to 4096 bytes
    send_read(5'd9, cur_gen, 40'hAB_CDEF_1234, 1'b0);
    fill_line(block_words());
    send_read(5'd9, cur_gen, 40'hAB_CDEF_1FFF, 1'b1);
    send_read(5'd9, cur_gen, 40'hAB_CDEF_1000, 1'b0);
    set_block_shift(4'd12);
  endtask

  // one block: a read, its fill if it missed, then a few reads of the same block
  task automatic run_block_access();
    logic [4:0]  slot;
    logic [39:0] base;
    logic [39:0] span;
    block_ref_t  ref_blk;
    int sh;
    int k;
    int words;
    sh = block_log2();
    span = (40'd1 << sh) - 40'd1;
    if (recent_blocks.size() > 0 && $urandom_range(1) == 1) begin
      ref_blk = recent_blocks[$urandom_range(recent_blocks.size() - 1)];
      slot = ref_blk.slot;
      base = ref_blk.base & ~span;
    end else begin
      slot = 5'($urandom);
      base = {8'($urandom), $urandom};
      if ($urandom_range(3) == 0) base = 40'($urandom_range(15)) << sh;
      base = base & ~span;
    end
    send_read(slot, cur_gen, base | ({8'($urandom), $urandom} & span), 1'($urandom));
    if (miss_busy) begin
      words = block_words();
      for (k = 0; k < words; k++) begin
        case ($urandom_range(199))
          0, 1, 2: send_read(5'($urandom), ($urandom_range(1) == 1) ? cur_gen : 16'($urandom),
                             {8'($urandom), $urandom}, 1'($urandom));
          3: send_op(OP_RESCAN);
          4: begin
            send_op(OP_FILL_ERROR);
            return;
          end
          default: ;
        endcase
        send_fill({$urandom, $urandom});
      end
      recent_blocks.push_back('{slot: slot, base: base});
      if (recent_blocks.size() > 12) void'(recent_blocks.pop_front());
    end
    repeat ($urandom_range(1, 6)) begin
      send_read(slot, ($urandom_range(7) == 0) ? 16'($urandom) : cur_gen,
                base | ({8'($urandom), $urandom} & span), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input logic [3:0] shift_val, input bit hold_off);
    int stop_at;
    bit paused;
    set_block_shift(shift_val);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    stop_at = items_sent + 220;
    paused = 1'b0;
    while (items_sent < stop_at) begin
      if (hold_off && !paused && items_sent >= stop_at - 110) begin
        paused = 1'b1;
        wait_results_done(0);
      end
      if ($urandom_range(9) == 0) begin
        send_request(2'($urandom), 5'($urandom),
                     ($urandom_range(1) == 1) ? cur_gen : 16'($urandom),
                     {8'($urandom), $urandom}, 1'($urandom), {$urandom, $urandom});
      end else begin
        run_block_access();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_READ;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shift_reg = SHIFT_RESET;
    cur_gen = '0;
    line_ok = '0;
    miss_busy = 1'b0;
    pend_lba = '0;
    pend_slot = '0;
    pend_off = '0;
    pend_last = 1'b0;
    fill_cnt = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_block_sizes();
    test_random_traffic(33, 60, 4'd0, 1'b0);
    test_random_traffic(60, 33, 4'd10, 1'b1);
    test_random_traffic(0, 0, 4'd9, 1'b0);
    wait_results_done(10);
    if (fails == 0 && pending_replies.size() == 0) begin
      $display("direct_mapped_block_read_cache_unit_tb OK");
    end else begin
      $display("direct_mapped_block_read_cache_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
